FILE: rtl/ring_buffer_moving_average_macros.svh
`ifndef RING_BUFFER_MOVING_AVERAGE_MACROS_SVH
`define RING_BUFFER_MOVING_AVERAGE_MACROS_SVH

// check a condition at every clock edge out of reset
`define RBMA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define RBMA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rbma_pkg.sv
`default_nettype none

package rbma_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned FILL_W     = 7;
  localparam int unsigned IN_TDATA_W = 16;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACCUM,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/ring_buffer_moving_average.sv
// Flow: accept a sample in idle, read the oldest entry, update the sum, divide, load the output.
//   The divider takes SUM_W = 16 + clog2(WINDOW+1) quotient steps, i.e. 23 at WINDOW = 100.
// The one-bit-per-cycle divider runs to completion before the next item is accepted.
// Input is accepted only in idle; a finished result may wait in the output register.
// Reset clears count, pointer, sum and control; store entries are masked by the fill
//   count until written, so no clearing pass follows reset.
`default_nettype none

`include "ring_buffer_moving_average_macros.svh"

module ring_buffer_moving_average #(
  parameter int unsigned WINDOW = 100
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [15:0] sample
  input  wire logic [rbma_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [15:0] average, [22:16] fill_count, [23] zero
  output logic [rbma_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

  import rbma_pkg::*;

  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned PTR_W  = $clog2(WINDOW);
  localparam int unsigned SUM_W  = DATA_W + CNT_W;
  localparam int unsigned STEP_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0]  WIN_CNT   = CNT_W'(WINDOW);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(WINDOW - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

  state_e state_q, state_d;

  logic [DATA_W-1:0] mem_q [WINDOW];
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] sample_q;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W:0]    rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              neg_q, neg_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] avg_q, avg_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  logic              in_fire;
  logic              mem_re;
  logic              mem_we;
  logic              out_load;
  logic [SUM_W-1:0]  old_ext;
  logic [SUM_W-1:0]  new_ext;
  logic [CNT_W:0]    rem_sh;
  logic              rem_ge;
  logic [SUM_W-1:0]  res;
  logic [CNT_W+FILL_W-1:0] fill_ext;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_READ;
      ST_READ:  state_d = ST_ACCUM;
      ST_ACCUM: state_d = ST_DIV;
      ST_DIV:   if (step_q == '0) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_READ:  mem_re = 1'b1;
      ST_ACCUM: mem_we = 1'b1;
      ST_DIV:   ;
      ST_DONE:  out_load = !out_valid_q || m_axis_tready;
      default:  ;
    endcase
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign new_ext = {{(SUM_W - DATA_W){sample_q[DATA_W-1]}}, sample_q};
  assign old_ext = (cnt_q == WIN_CNT) ? {{(SUM_W - DATA_W){rd_q[DATA_W-1]}}, rd_q} : '0;

  assign rem_sh = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, cnt_q};

  assign res      = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
  assign fill_ext = {{FILL_W{1'b0}}, cnt_q};

  // datapath
  always_comb begin
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    step_d      = step_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;
    avg_d       = avg_q;
    fill_d      = fill_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (mem_we) begin
      sum_d  = sum_q + new_ext - old_ext;
      ptr_d  = (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
      cnt_d  = (cnt_q == WIN_CNT) ? cnt_q : cnt_q + CNT_W'(1);
      neg_d  = sum_d[SUM_W-1];
      quo_d  = sum_d[SUM_W-1] ? (~sum_d + SUM_W'(1)) : sum_d;
      rem_d  = '0;
      step_d = STEP_LAST;
    end

    if (state_q == ST_DIV) begin
      quo_d  = {quo_q[SUM_W-2:0], rem_ge};
      rem_d  = rem_ge ? (rem_sh - {1'b0, cnt_q}) : rem_sh;
      step_d = step_q - STEP_W'(1);
    end

    if (out_load) begin
      out_valid_d = 1'b1;
      avg_d       = res[DATA_W-1:0];
      fill_d      = fill_ext[FILL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= s_axis_tdata[DATA_W-1:0];
    end
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    neg_q  <= neg_d;
    avg_q  <= avg_d;
    fill_q <= fill_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[ptr_q] <= sample_q;
    end
    if (mem_re) begin
      rd_q <= mem_q[ptr_q];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, fill_q, avg_q};

  `RBMA_ASSERT_ALWAYS(a_cnt_range, cnt_q <= WIN_CNT, "fill count above window")
  `RBMA_ASSERT_ALWAYS(a_ptr_range, ptr_q <= PTR_LAST, "write pointer out of range")
  `RBMA_ASSERT_IMPLY(a_fill_ptr, (state_q == ST_ACCUM) && (cnt_q != WIN_CNT),
    ptr_q == cnt_q[PTR_W-1:0], "pointer and fill count disagree while filling")
  `RBMA_ASSERT_IMPLY(a_out_src, $rose(out_valid_q), $past(state_q == ST_DONE),
    "output valid raised outside done state")

endmodule

`default_nettype wire
